// ===== hw/rtl/kcd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcd_pkg: shared types and constants for the click / double-click detector
// Phase and event codes, per-key state record and register reset values.
// ----------------------------------------------------------------------------
package kcd_pkg;

   localparam int unsigned KEY_IN_W = 2;
   localparam int unsigned HOLD_W   = 16;
   localparam int unsigned CSR_W    = 16;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [HOLD_W-1:0] HOLD_MAX = '1;

   localparam logic [CSR_W-1:0] FALL_CREDIT_RST = 16'd50;
   localparam logic [CSR_W-1:0] LONG_CREDIT_RST = 16'd500;
   localparam logic [CSR_W-1:0] SCAN_STEP_RST   = 16'd25;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FALL_CREDIT = 2'd0,
      CSR_LONG_CREDIT = 2'd1,
      CSR_SCAN_STEP   = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_UP_LONG    = 3'd0,
      PH_FALL       = 3'd1,
      PH_DOWN_SHORT = 3'd2,
      PH_DOWN_TRANS = 3'd3,
      PH_DOWN_LONG  = 3'd4,
      PH_RISE       = 3'd5,
      PH_UP_SHORT   = 3'd6,
      PH_UP_TRANS   = 3'd7
   } phase_type;

   typedef enum logic [2:0] {
      EV_NONE   = 3'd0,
      EV_DOWN   = 3'd1,
      EV_CLICK  = 3'd2,
      EV_UP     = 3'd3,
      EV_DOUBLE = 3'd4
   } event_type;

   typedef struct packed {
      phase_type         phase;
      logic [HOLD_W-1:0] hold;
      logic              long_seen;
   } key_state_type;

   typedef struct packed {
      logic [CSR_W-1:0] fall_credit;
      logic [CSR_W-1:0] long_credit;
      logic [CSR_W-1:0] scan_step;
   } credit_type;

endpackage

// ===== hw/rtl/kcd_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcd_req_if: scan sample channel
// One word is one debounced sample of one key.
// ----------------------------------------------------------------------------
interface kcd_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] key_index;
   logic       pressed;

   modport source (output valid, output key_index, output pressed, input ready);
   modport sink   (input valid, input key_index, input pressed, output ready);
endinterface

// ===== hw/rtl/kcd_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcd_rsp_if: key event channel
// One word per sample: new phase, event code and hold time of the key.
// ----------------------------------------------------------------------------
interface kcd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  key_out;
   logic [2:0]  key_phase;
   logic [2:0]  event_code;
   logic        release_report;
   logic [15:0] hold_time;

   modport source (output valid, output key_out, output key_phase, output event_code,
                   output release_report, output hold_time, input ready);
   modport sink   (input valid, input key_out, input key_phase, input event_code,
                   input release_report, input hold_time, output ready);
endinterface

// ===== hw/rtl/kcd_key_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcd_key_step: one step of the per-key click state machine
// Next phase, event and saturating hold timer update for one sample.
// ----------------------------------------------------------------------------
module kcd_key_step
   import kcd_pkg::*;
(
   input  key_state_type cur,
   input  logic          pressed,
   input  credit_type    credit,
   output key_state_type nxt,
   output event_type     evt
);

   logic [HOLD_W-1:0] addend;
   logic [HOLD_W:0]   sum;

   // first down-long sample takes the long credit, later ones the scan step
   assign addend = cur.long_seen ? credit.scan_step : credit.long_credit;
   assign sum    = {1'b0, cur.hold} + {1'b0, addend};

   always_comb begin
      nxt.phase = PH_UP_LONG;
      evt       = EV_NONE;
      unique case (cur.phase)
         PH_UP_LONG: begin
            nxt.phase = pressed ? PH_FALL : PH_UP_LONG;
         end
         PH_FALL: begin
            nxt.phase = pressed ? PH_DOWN_SHORT : PH_UP_SHORT;
            evt       = pressed ? EV_DOWN : EV_NONE;
         end
         PH_DOWN_SHORT: begin
            nxt.phase = pressed ? PH_DOWN_TRANS : PH_RISE;
         end
         PH_DOWN_TRANS: begin
            nxt.phase = pressed ? PH_DOWN_LONG : PH_RISE;
            evt       = pressed ? EV_NONE : EV_CLICK;
         end
         PH_DOWN_LONG: begin
            nxt.phase = pressed ? PH_DOWN_LONG : PH_RISE;
         end
         PH_RISE: begin
            nxt.phase = pressed ? PH_DOWN_SHORT : PH_UP_SHORT;
            evt       = pressed ? EV_NONE : EV_UP;
         end
         PH_UP_SHORT: begin
            nxt.phase = pressed ? PH_FALL : PH_UP_TRANS;
         end
         PH_UP_TRANS: begin
            nxt.phase = pressed ? PH_FALL : PH_UP_LONG;
            evt       = pressed ? EV_DOUBLE : EV_NONE;
         end
         default: begin
            nxt.phase = PH_UP_LONG;
         end
      endcase

      nxt.hold      = cur.hold;
      nxt.long_seen = 1'b0;
      if (nxt.phase == PH_DOWN_SHORT) begin
         nxt.hold = credit.fall_credit;
      end else if (nxt.phase == PH_DOWN_LONG) begin
         nxt.long_seen = 1'b1;
         nxt.hold      = sum[HOLD_W] ? HOLD_MAX : sum[HOLD_W-1:0];
      end
   end

endmodule

// ===== hw/rtl/key_click_doubleclick_fsm_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_click_doubleclick_fsm_top: per-key click / double-click detector
// Steps an eight-phase machine per key on each scan sample and reports
// key down, click, key up and double click with the key's hold time.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  req_if    in   valid/ready   key_index, pressed
//  rsp_if    out  valid/ready   key_out, key_phase, event_code,
//                               release_report, hold_time
//  csr_*     in   write enable  csr_index, csr_write_data (no read-back)
//
// One sample per cycle while the output is not stalled; its result word
// appears in the cycle after acceptance. Per-key state is read and written
// in the accepting cycle, so samples of the same key back to back see each
// other's update. A stalled result word holds in the output register; a new
// sample is taken in the cycle the held word leaves. Synchronous reset puts
// every key in up long with a zero timer and restores the register defaults.
// ----------------------------------------------------------------------------
module key_click_doubleclick_fsm_top
   import kcd_pkg::*;
#(
   parameter int KEYS = 4
)(
   input  logic                 clock,
   input  logic                 reset,
   kcd_req_if.sink              req_if,
   kcd_rsp_if.source            rsp_if,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_write_data
);

   localparam int KEY_W = (KEYS > 1) ? $clog2(KEYS) : 1;

   credit_type credit_ff;

   phase_type         phase_ff [KEYS];
   logic [HOLD_W-1:0] hold_ff  [KEYS];
   logic              long_ff  [KEYS];

   logic [KEY_W-1:0]  key_sel;
   logic              key_ok;
   logic              req_fire;
   key_state_type     cur;
   key_state_type     nxt;
   event_type         evt;

   logic                rsp_valid_ff;
   logic [KEY_IN_W-1:0] rsp_key_ff;
   phase_type           rsp_phase_ff;
   event_type           rsp_event_ff;
   logic                rsp_report_ff;
   logic [HOLD_W-1:0]   rsp_hold_ff;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff.fall_credit <= FALL_CREDIT_RST;
         credit_ff.long_credit <= LONG_CREDIT_RST;
         credit_ff.scan_step   <= SCAN_STEP_RST;
      end else if (csr_write_en) begin
         if (csr_index == CSR_FALL_CREDIT) begin
            credit_ff.fall_credit <= csr_write_data;
         end else if (csr_index == CSR_LONG_CREDIT) begin
            credit_ff.long_credit <= csr_write_data;
         end else if (csr_index == CSR_SCAN_STEP) begin
            credit_ff.scan_step <= csr_write_data;
         end
      end
   end

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_fire     = req_if.valid && req_if.ready;

   assign key_sel = KEY_W'(req_if.key_index);
   assign key_ok  = int'(req_if.key_index) < KEYS;

   always_comb begin
      cur.phase     = PH_UP_LONG;
      cur.hold      = '0;
      cur.long_seen = 1'b0;
      if (key_ok) begin
         cur.phase     = phase_ff[key_sel];
         cur.hold      = hold_ff[key_sel];
         cur.long_seen = long_ff[key_sel];
      end
   end

   kcd_key_step u_step (
      .cur     (cur),
      .pressed (req_if.pressed),
      .credit  (credit_ff),
      .nxt     (nxt),
      .evt     (evt)
   );

   // per-key state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < KEYS; k++) begin
            phase_ff[k] <= PH_UP_LONG;
            hold_ff[k]  <= '0;
            long_ff[k]  <= 1'b0;
         end
      end else if (req_fire && key_ok) begin
         phase_ff[key_sel] <= nxt.phase;
         hold_ff[key_sel]  <= nxt.hold;
         long_ff[key_sel]  <= nxt.long_seen;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // out-of-range key: echo the index, zero everything else
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_key_ff    <= req_if.key_index;
         rsp_phase_ff  <= key_ok ? nxt.phase : PH_UP_LONG;
         rsp_event_ff  <= key_ok ? evt : EV_NONE;
         rsp_report_ff <= key_ok && (nxt.phase == PH_UP_SHORT);
         rsp_hold_ff   <= key_ok ? nxt.hold : '0;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.key_out        = rsp_key_ff;
   assign rsp_if.key_phase      = rsp_phase_ff;
   assign rsp_if.event_code     = rsp_event_ff;
   assign rsp_if.release_report = rsp_report_ff;
   assign rsp_if.hold_time      = rsp_hold_ff;

   a_fire_gives_word: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted sample produced no result word");

   a_report_matches_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_report_ff == (rsp_phase_ff == PH_UP_SHORT)))
      else $error("release report disagrees with phase");

   a_double_enters_fall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_event_ff == EV_DOUBLE) |-> (rsp_phase_ff == PH_FALL))
      else $error("double click outside fall phase");

   a_down_short_loads_credit: assert property (@(posedge clock) disable iff (reset)
      (req_fire && key_ok && nxt.phase == PH_DOWN_SHORT)
         |=> (rsp_hold_ff == $past(credit_ff.fall_credit)))
      else $error("down short did not load fall credit");

endmodule

// ===== sim/key_click_doubleclick_fsm_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_click_doubleclick_fsm_top_tb: self-checking bench for the click detector
// Drives scan samples through the request channel and checks every event
// word against a per-key phase machine kept in the bench. The bench walks
// every phase move, runs the credit registers at their extremes and at random
// settings, forces output backpressure, and plays random press/release
// gestures over all keys.
// ----------------------------------------------------------------------------
module key_click_doubleclick_fsm_top_tb;
   import kcd_pkg::*;

   localparam int KEYS = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_IDX = 2'd3;
   // pressed level per sample for a walk through all sixteen phase moves
   localparam bit [0:19] PHASE_WALK = 20'b0100_1101_1001_1111_0000;

   typedef struct {
      logic [KEY_IN_W-1:0] key;
      phase_type           phase;
      event_type           ev;
      logic                report;
      logic [HOLD_W-1:0]   hold;
   } key_event_type;

   logic clock;
   logic reset;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_write_data;

   kcd_req_if req_if();
   kcd_rsp_if rsp_if();

   key_click_doubleclick_fsm_top #(
      .KEYS (KEYS)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_if         (req_if),
      .rsp_if         (rsp_if),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   // bench copy of the per-key machines and credits
   phase_type         key_phase [KEYS];
   logic [HOLD_W-1:0] key_hold [KEYS];
   bit                key_long_seen [KEYS];
   logic [CSR_W-1:0]  fall_credit;
   logic [CSR_W-1:0]  long_credit;
   logic [CSR_W-1:0]  scan_step;

   key_event_type pending_events[$];
   int  mismatch_count = 0;
   bit  quiet = 1'b0;
   int  stall_cycles = 0;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   initial begin
      #6_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [HOLD_W-1:0] sat_add(logic [HOLD_W-1:0] a, logic [HOLD_W-1:0] b);
      logic [HOLD_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[HOLD_W] ? HOLD_MAX : sum[HOLD_W-1:0];
   endfunction

   function automatic void clear_key_machines();
      for (int k = 0; k < KEYS; k++) begin
         key_phase[k]     = PH_UP_LONG;
         key_hold[k]      = '0;
         key_long_seen[k] = 1'b0;
      end
      fall_credit = FALL_CREDIT_RST;
      long_credit = LONG_CREDIT_RST;
      scan_step   = SCAN_STEP_RST;
   endfunction

   function automatic key_event_type step_key_machine(logic [KEY_IN_W-1:0] key, logic pressed);
      key_event_type res;
      phase_type     nxt;
      event_type     ev;
      ev = EV_NONE;
      case (key_phase[key])
         PH_UP_LONG:    nxt = pressed ? PH_FALL : PH_UP_LONG;
         PH_FALL: begin
            nxt = pressed ? PH_DOWN_SHORT : PH_UP_SHORT;
            if (pressed) ev = EV_DOWN;
         end
         PH_DOWN_SHORT: nxt = pressed ? PH_DOWN_TRANS : PH_RISE;
         PH_DOWN_TRANS: begin
            nxt = pressed ? PH_DOWN_LONG : PH_RISE;
            if (!pressed) ev = EV_CLICK;
         end
         PH_DOWN_LONG:  nxt = pressed ? PH_DOWN_LONG : PH_RISE;
         PH_RISE: begin
            nxt = pressed ? PH_DOWN_SHORT : PH_UP_SHORT;
            if (!pressed) ev = EV_UP;
         end
         PH_UP_SHORT:   nxt = pressed ? PH_FALL : PH_UP_TRANS;
         default: begin
            nxt = pressed ? PH_FALL : PH_UP_LONG;
            if (pressed) ev = EV_DOUBLE;
         end
      endcase
      key_phase[key] = nxt;
      if (nxt != PH_DOWN_LONG) key_long_seen[key] = 1'b0;
      if (nxt == PH_DOWN_SHORT) begin
         key_hold[key] = fall_credit;
      end else if (nxt == PH_DOWN_LONG) begin
         // long credit once on entry, scan step on every sample after
         if (key_long_seen[key]) begin
            key_hold[key] = sat_add(key_hold[key], scan_step);
         end else begin
            key_long_seen[key] = 1'b1;
            key_hold[key] = sat_add(key_hold[key], long_credit);
         end
      end
      res.key    = key;
      res.phase  = nxt;
      res.ev     = ev;
      res.report = (nxt == PH_UP_SHORT);
      res.hold   = key_hold[key];
      return res;
   endfunction

   // call at a rising edge; returns at the edge where the word is taken
   task automatic send_sample(logic [KEY_IN_W-1:0] key, logic pressed);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.key_index <= key;
      req_if.pressed   <= pressed;
      do @(posedge clock); while (!req_if.ready);
      pending_events.push_back(step_key_machine(key, pressed));
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_credit(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] value);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_FALL_CREDIT: fall_credit = value;
         CSR_LONG_CREDIT: long_credit = value;
         CSR_SCAN_STEP:   scan_step   = value;
         default: ;
      endcase
   endtask

   task automatic set_credits(logic [CSR_W-1:0] fall, logic [CSR_W-1:0] long_add,
                              logic [CSR_W-1:0] step);
      wait_idle();
      write_credit(CSR_FALL_CREDIT, fall);
      write_credit(CSR_LONG_CREDIT, long_add);
      write_credit(CSR_SCAN_STEP, step);
   endtask

   // hold the key for press_len samples, then release for four
   task automatic long_press(logic [KEY_IN_W-1:0] key, int press_len);
      repeat (press_len) send_sample(key, 1'b1);
      repeat (4) send_sample(key, 1'b0);
   endtask

   task automatic report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= 10) $display("mismatch: %s", what);
   endtask

   // receiver: random stalls, plus a counted hold-off when requested
   initial begin : rsp_ready_gen
      int ready_wait;
      ready_wait = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_cycles > 0) begin
            rsp_if.ready <= 1'b0;
            stall_cycles--;
         end else if (ready_wait > 0) begin
            rsp_if.ready <= 1'b0;
            ready_wait--;
         end else begin
            rsp_if.ready <= 1'b1;
            ready_wait = pick_gap();
         end
      end
   end

   always @(posedge clock) begin : check_events
      key_event_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_events.size() == 0) begin
            report_mismatch($sformatf("word for key %0d with nothing expected", rsp_if.key_out));
         end else begin
            want = pending_events.pop_front();
            if (rsp_if.key_out !== want.key || rsp_if.key_phase !== want.phase ||
                rsp_if.event_code !== want.ev || rsp_if.release_report !== want.report ||
                rsp_if.hold_time !== want.hold)
               report_mismatch($sformatf(
                  "exp key %0d ph %0d ev %0d rep %0d hold %0d, got %0d %0d %0d %0d %0d",
                  want.key, want.phase, want.ev, want.report, want.hold,
                  rsp_if.key_out, rsp_if.key_phase, rsp_if.event_code,
                  rsp_if.release_report, rsp_if.hold_time));
         end
      end
   end

   // every phase move at least once on the top key, a few words on the others
   task automatic test_phase_walk();
      for (int i = 0; i < 20; i++) send_sample(2'd3, PHASE_WALK[i]);
      send_sample(2'd0, 1'b1);
      send_sample(2'd1, 1'b1);
      send_sample(2'd2, 1'b1);
      send_sample(2'd0, 1'b0);
   endtask

   task automatic test_credit_extremes();
      set_credits(16'hFFFF, 16'hFFFF, 16'hFFFF);
      long_press(2'd2, 8);
      set_credits(16'h0000, 16'h0000, 16'h0000);
      long_press(2'd1, 6);
      // unused index must leave the credits alone
      wait_idle();
      write_credit(CSR_UNUSED_IDX, 16'hFFFF);
      long_press(2'd0, 6);
      // timer climbs into saturation one step at a time
      set_credits(16'd65000, 16'd500, 16'd25);
      long_press(2'd3, 7);
      set_credits(FALL_CREDIT_RST, LONG_CREDIT_RST, SCAN_STEP_RST);
   endtask

   task automatic test_back_to_back();
      quiet = 1'b1;
      repeat (60) send_sample(2'd1, 1'($urandom_range(0, 1)));
      quiet = 1'b0;
   endtask

   // receiver holds off while samples keep coming; input must stall
   task automatic test_output_stall();
      quiet = 1'b1;
      stall_cycles = 100;
      for (int i = 0; i < 30; i++) send_sample(2'(i), 1'(i >> 2));
      quiet = 1'b0;
   endtask

   // interleaved press/release runs per key, with some stray samples
   task automatic run_gestures(int count);
      int   run_left [KEYS];
      logic level [KEYS];
      logic [KEY_IN_W-1:0] key;
      logic p;
      for (int k = 0; k < KEYS; k++) begin
         run_left[k] = 0;
         level[k] = 1'b0;
      end
      for (int i = 0; i < count; i++) begin
         if (i % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
         key = KEY_IN_W'($urandom_range(0, KEYS - 1));
         if ($urandom_range(0, 9) == 0) begin
            p = 1'($urandom_range(0, 1));
         end else begin
            if (run_left[key] == 0) begin
               level[key] = !level[key];
               if (!level[key])
                  run_left[key] = $urandom_range(1, 4);
               else if ($urandom_range(0, 4) == 0)
                  run_left[key] = $urandom_range(6, 30);
               else
                  run_left[key] = $urandom_range(1, 5);
            end
            run_left[key]--;
            p = level[key];
         end
         send_sample(key, p);
      end
      quiet = 1'b0;
   endtask

   task automatic test_random_gestures();
      run_gestures(440);
      set_credits(CSR_W'($urandom_range(0, 200)), CSR_W'($urandom_range(0, 1000)),
                  CSR_W'($urandom_range(0, 100)));
      run_gestures(440);
      set_credits(CSR_W'($urandom_range(0, 65535)), CSR_W'($urandom_range(0, 65535)),
                  CSR_W'($urandom_range(0, 65535)));
      run_gestures(440);
      set_credits(CSR_W'($urandom_range(60000, 65535)), CSR_W'($urandom_range(1000, 5000)),
                  CSR_W'($urandom_range(100, 2000)));
      run_gestures(440);
   endtask

   initial begin : run_tests
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.key_index = '0;
      req_if.pressed   = 1'b0;
      csr_write_en     = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      clear_key_machines();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_phase_walk();
      test_credit_extremes();
      test_back_to_back();
      test_output_stall();
      test_random_gestures();

      wait_idle();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && pending_events.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== key_click_doubleclick_fsm_top.f =====
hw/rtl/kcd_pkg.sv
hw/rtl/kcd_req_if.sv
hw/rtl/kcd_rsp_if.sv
hw/rtl/kcd_key_step.sv
hw/rtl/key_click_doubleclick_fsm_top.sv
sim/key_click_doubleclick_fsm_top_tb.sv
